FILE: rtl/core/tmu_pkg.sv
// tmu_pkg: beat types, widths and helpers of the triangle measure unit
// used by every module under rtl/core, no dependencies

package tmu_pkg;

   // fixed field geometry
   localparam int COORD_BITS = 16;
   localparam int FRAC_BITS  = 8;
   localparam int CEN_W      = 24;
   localparam int PER_W      = 27;
   localparam int AREA_W     = 33;

   // derived internal widths
   localparam int DIFF_W   = COORD_BITS + 1;
   localparam int MAG_W    = COORD_BITS;
   localparam int PROD_W   = 2 * MAG_W;
   localparam int SQ_W     = PROD_W + 1;
   localparam int ROOT_W   = (SQ_W + 2 * FRAC_BITS + 1) / 2;
   localparam int RAD_W    = 2 * ROOT_W;
   localparam int REM_W    = ROOT_W + 1;
   localparam int SUM_W    = COORD_BITS + 2;
   localparam int NUM_W    = SUM_W - 1 + FRAC_BITS;
   localparam int CROSS_W  = 2 * DIFF_W;
   localparam int CDIFF_W  = CROSS_W + 1;

   // divide by three: reciprocal 2^26/3 rounded up, exact for numerators below 2^25
   localparam int DIV3_SHIFT = NUM_W + 1;
   localparam int DIV_PROD_W = 2 * NUM_W;
   localparam logic [NUM_W-1:0] DIV3_MULT = NUM_W'((64'(1) << DIV3_SHIFT) / 3 + 1);

   typedef struct packed {
      logic signed [COORD_BITS-1:0] ax;
      logic signed [COORD_BITS-1:0] ay;
      logic signed [COORD_BITS-1:0] bx;
      logic signed [COORD_BITS-1:0] by_coord;
      logic signed [COORD_BITS-1:0] cx;
      logic signed [COORD_BITS-1:0] cy;
   } req_type;

   typedef struct packed {
      logic signed [CEN_W-1:0] centroid_x;
      logic signed [CEN_W-1:0] centroid_y;
      logic [PER_W-1:0]        perimeter;
      logic [AREA_W-1:0]       double_area;
   } rsp_type;

   // fields that ride alongside the square roots
   typedef struct packed {
      logic signed [CEN_W-1:0] centroid_x;
      logic signed [CEN_W-1:0] centroid_y;
      logic [AREA_W-1:0]       double_area;
   } tail_type;

   typedef struct packed {
      tail_type          tail;
      logic [SQ_W-1:0]   sq_ab;
      logic [SQ_W-1:0]   sq_ac;
      logic [SQ_W-1:0]   sq_bc;
   } prep_type;

   // magnitude of a coordinate difference
   function automatic logic [MAG_W-1:0] mag_diff(input logic signed [DIFF_W-1:0] d);
      logic [DIFF_W-1:0] n;
      n = d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
      return n[MAG_W-1:0];
   endfunction

endpackage

FILE: rtl/core/tmu_prep.sv
// tmu_prep: three register stages of differences, products and the centroid
// depends on tmu_pkg

module tmu_prep import tmu_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     advance,
   input  logic     in_valid,
   input  req_type  in_data,
   output logic     out_valid,
   output prep_type out_data
);

   // stage 1 registers
   logic v1_ff;
   logic signed [DIFF_W-1:0] dabx_ff, daby_ff, dacx_ff, dacy_ff, dbcx_ff, dbcy_ff;
   logic signed [SUM_W-1:0]  sumx_ff, sumy_ff;
   // stage 2 registers
   logic v2_ff;
   logic [PROD_W-1:0] sq_abx_ff, sq_aby_ff, sq_acx_ff, sq_acy_ff, sq_bcx_ff, sq_bcy_ff;
   logic signed [CROSS_W-1:0] p1_ff, p2_ff;
   logic [DIV_PROD_W-1:0] qx_ff, qy_ff;
   logic negx_ff, negy_ff;
   // stage 3 registers
   logic v3_ff;
   prep_type out_ff;

   logic [MAG_W-1:0] m_abx, m_aby, m_acx, m_acy, m_bcx, m_bcy;
   logic [SUM_W-1:0] absx, absy;
   logic [NUM_W-1:0] numx, numy;
   logic signed [CDIFF_W-1:0] cross_prod;
   logic [CDIFF_W-1:0] cross_abs;
   logic [CEN_W-1:0] qx, qy;
   prep_type out_in;

   // stage 2 operands
   always_comb begin
      m_abx = mag_diff(dabx_ff);
      m_aby = mag_diff(daby_ff);
      m_acx = mag_diff(dacx_ff);
      m_acy = mag_diff(dacy_ff);
      m_bcx = mag_diff(dbcx_ff);
      m_bcy = mag_diff(dbcy_ff);
      absx  = sumx_ff[SUM_W-1] ? SUM_W'(-sumx_ff) : SUM_W'(sumx_ff);
      absy  = sumy_ff[SUM_W-1] ? SUM_W'(-sumy_ff) : SUM_W'(sumy_ff);
      numx  = {absx[SUM_W-2:0], FRAC_BITS'(0)};
      numy  = {absy[SUM_W-2:0], FRAC_BITS'(0)};
   end

   // stage 3 results
   always_comb begin
      cross_prod = CDIFF_W'(p1_ff) - CDIFF_W'(p2_ff);
      cross_abs  = cross_prod[CDIFF_W-1] ? CDIFF_W'(-cross_prod) : CDIFF_W'(cross_prod);
      qx         = qx_ff[DIV3_SHIFT +: CEN_W];
      qy         = qy_ff[DIV3_SHIFT +: CEN_W];
      out_in.tail.centroid_x  = negx_ff ? CEN_W'(-qx) : qx;
      out_in.tail.centroid_y  = negy_ff ? CEN_W'(-qy) : qy;
      out_in.tail.double_area = cross_abs[AREA_W-1:0];
      out_in.sq_ab = SQ_W'(sq_abx_ff) + SQ_W'(sq_aby_ff);
      out_in.sq_ac = SQ_W'(sq_acx_ff) + SQ_W'(sq_acy_ff);
      out_in.sq_bc = SQ_W'(sq_bcx_ff) + SQ_W'(sq_bcy_ff);
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (advance) begin
         dabx_ff <= DIFF_W'(in_data.bx) - DIFF_W'(in_data.ax);
         daby_ff <= DIFF_W'(in_data.by_coord) - DIFF_W'(in_data.ay);
         dacx_ff <= DIFF_W'(in_data.cx) - DIFF_W'(in_data.ax);
         dacy_ff <= DIFF_W'(in_data.cy) - DIFF_W'(in_data.ay);
         dbcx_ff <= DIFF_W'(in_data.cx) - DIFF_W'(in_data.bx);
         dbcy_ff <= DIFF_W'(in_data.cy) - DIFF_W'(in_data.by_coord);
         sumx_ff <= SUM_W'(in_data.ax) + SUM_W'(in_data.bx) + SUM_W'(in_data.cx);
         sumy_ff <= SUM_W'(in_data.ay) + SUM_W'(in_data.by_coord) + SUM_W'(in_data.cy);

         sq_abx_ff <= PROD_W'(m_abx) * PROD_W'(m_abx);
         sq_aby_ff <= PROD_W'(m_aby) * PROD_W'(m_aby);
         sq_acx_ff <= PROD_W'(m_acx) * PROD_W'(m_acx);
         sq_acy_ff <= PROD_W'(m_acy) * PROD_W'(m_acy);
         sq_bcx_ff <= PROD_W'(m_bcx) * PROD_W'(m_bcx);
         sq_bcy_ff <= PROD_W'(m_bcy) * PROD_W'(m_bcy);
         p1_ff     <= CROSS_W'(dabx_ff) * CROSS_W'(dacy_ff);
         p2_ff     <= CROSS_W'(daby_ff) * CROSS_W'(dacx_ff);
         qx_ff     <= DIV_PROD_W'(numx) * DIV_PROD_W'(DIV3_MULT);
         qy_ff     <= DIV_PROD_W'(numy) * DIV_PROD_W'(DIV3_MULT);
         negx_ff   <= sumx_ff[SUM_W-1];
         negy_ff   <= sumy_ff[SUM_W-1];

         out_ff <= out_in;
      end
   end

   assign out_valid = v3_ff;
   assign out_data  = out_ff;

endmodule

FILE: rtl/core/tmu_isqrt.sv
// tmu_isqrt: pipelined integer square root, one result bit per register stage
// depends on tmu_pkg

module tmu_isqrt import tmu_pkg::*; (
   input  logic              clock,
   input  logic              advance,
   input  logic [RAD_W-1:0]  radicand,
   output logic [ROOT_W-1:0] root
);

   logic [REM_W-1:0]  rem_ff  [ROOT_W];
   logic [ROOT_W-1:0] root_ff [ROOT_W];
   logic [RAD_W-1:0]  rad_ff  [ROOT_W];

   for (genvar k = 0; k < ROOT_W; k++) begin : g_step
      logic [REM_W-1:0]  rem_prev;
      logic [ROOT_W-1:0] root_prev;
      logic [RAD_W-1:0]  rad_prev;
      logic [REM_W+1:0]  cur;
      logic [REM_W+1:0]  trial;
      logic [REM_W+1:0]  diff;
      logic              take;

      if (k == 0) begin : g_first
         assign rem_prev  = '0;
         assign root_prev = '0;
         assign rad_prev  = radicand;
      end else begin : g_next
         assign rem_prev  = rem_ff[k-1];
         assign root_prev = root_ff[k-1];
         assign rad_prev  = rad_ff[k-1];
      end

      // bring down two radicand bits and try root*4+1
      always_comb begin
         cur   = {rem_prev, rad_prev[RAD_W-1 -: 2]};
         trial = (REM_W+2)'({root_prev, 2'b01});
         diff  = cur - trial;
         take  = (cur >= trial);
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[k]  <= take ? diff[REM_W-1:0] : cur[REM_W-1:0];
            root_ff[k] <= {root_prev[ROOT_W-2:0], take};
            rad_ff[k]  <= {rad_prev[RAD_W-3:0], 2'b00};
         end
      end
   end

   assign root = root_ff[ROOT_W-1];

endmodule

FILE: rtl/core/triangle_measure_unit.sv
// triangle_measure_unit: centroid, perimeter and twice the area of one triangle per beat
// pipeline of 3 prep stages, 25 square root stages and 1 perimeter/output stage
// throughput one beat per cycle; the whole pipeline holds while the output beat is stalled
// synchronous active-high reset clears the valid bits only, no other state
// depends on tmu_pkg, tmu_prep, tmu_isqrt

module triangle_measure_unit import tmu_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic     advance;
   logic     prep_valid;
   prep_type prep_data;
   logic [ROOT_W-1:0] side_ab, side_ac, side_bc;

   logic     vld_ff  [ROOT_W];
   tail_type tail_ff [ROOT_W];
   logic     rsp_valid_ff;
   rsp_type  rsp_ff;
   rsp_type  rsp_in;

   // pipeline moves unless the output beat is held
   assign advance   = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !advance;

   tmu_prep u_prep (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (req_valid),
      .in_data   (req_data),
      .out_valid (prep_valid),
      .out_data  (prep_data)
   );

   // three side lengths in parallel
   tmu_isqrt u_sqrt_ab (
      .clock    (clock),
      .advance  (advance),
      .radicand (RAD_W'({prep_data.sq_ab, (2*FRAC_BITS)'(0)})),
      .root     (side_ab)
   );

   tmu_isqrt u_sqrt_ac (
      .clock    (clock),
      .advance  (advance),
      .radicand (RAD_W'({prep_data.sq_ac, (2*FRAC_BITS)'(0)})),
      .root     (side_ac)
   );

   tmu_isqrt u_sqrt_bc (
      .clock    (clock),
      .advance  (advance),
      .radicand (RAD_W'({prep_data.sq_bc, (2*FRAC_BITS)'(0)})),
      .root     (side_bc)
   );

   // valid bits alongside the root stages
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ROOT_W; i++) begin
            vld_ff[i] <= 1'b0;
         end
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         vld_ff[0] <= prep_valid;
         for (int i = 1; i < ROOT_W; i++) begin
            vld_ff[i] <= vld_ff[i-1];
         end
         rsp_valid_ff <= vld_ff[ROOT_W-1];
      end
   end

   // centroid and area delay line
   always_ff @(posedge clock) begin
      if (advance) begin
         tail_ff[0] <= prep_data.tail;
         for (int i = 1; i < ROOT_W; i++) begin
            tail_ff[i] <= tail_ff[i-1];
         end
         rsp_ff <= rsp_in;
      end
   end

   // perimeter sum and output beat
   always_comb begin
      rsp_in.centroid_x  = tail_ff[ROOT_W-1].centroid_x;
      rsp_in.centroid_y  = tail_ff[ROOT_W-1].centroid_y;
      rsp_in.double_area = tail_ff[ROOT_W-1].double_area;
      rsp_in.perimeter   = PER_W'(side_ab) + PER_W'(side_ac) + PER_W'(side_bc);
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // input held only because the output beat is held
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid_ff)
      else $error("input stalled without a held output beat");

   // a beat at the end of the root stages reaches the output
   a_tail_to_out: assert property (@(posedge clock) disable iff (reset)
      (advance && vld_ff[ROOT_W-1]) |=> rsp_valid_ff)
      else $error("beat lost before the output");

   // a bubble at the end of the root stages gives no output beat
   a_no_invent: assert property (@(posedge clock) disable iff (reset)
      (advance && !vld_ff[ROOT_W-1]) |=> !rsp_valid_ff)
      else $error("output beat without a source");

   // a held output beat freezes the first and last root stage valid bits
   a_hold_stages: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(vld_ff[ROOT_W-1]) && $stable(vld_ff[0]))
      else $error("pipeline moved during a stall");

endmodule
